// ===== rtl/core/sacf_pkg.sv =====
package sacf_pkg;

    localparam int DEF_MAX_SETS = 128;
    localparam int DEF_MAX_WAYS = 8;
    localparam int DEF_MEMORY_BLOCKS = 1024;

    localparam int DVD_W = 32;
    localparam int DVS_W = 13;
    localparam int REM_W = DVS_W + 1;
    localparam int STEP_W = 6;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WORDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SET_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAY_COUNT = 2'd2;

    localparam logic [12:0] BLOCK_WORDS_RST = 13'd4;
    localparam logic [12:0] BLOCK_WORDS_LIMIT = 13'd4096;
    localparam logic [7:0] SET_COUNT_RST = 8'd8;
    localparam logic [3:0] WAY_COUNT_RST = 4'd1;

    localparam logic [1:0] OUT_HIT = 2'd0;
    localparam logic [1:0] OUT_COMPULSORY = 2'd1;
    localparam logic [1:0] OUT_CAPACITY = 2'd2;
    localparam logic [1:0] OUT_RANGE = 2'd3;

    typedef struct packed {
        logic start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [DVD_W-1:0] quotient;
        logic [REM_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== rtl/core/set_assoc_cache_fifo_miss_classifier_top.sv =====
// Set-associative tag store with FIFO replacement that classifies misses.
// Input channel s_*: one memory word index per item. Result channel m_*: one
// item per input with the outcome (hit, compulsory miss, capacity miss or
// block out of range), the set where the block was found or filled, and the
// five access counters after this access.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 block_words,
// 1 set_count, 2 way_count) while the block is idle; the user must keep to this, the block itself does not enforce it.
// Per item: the 32-step block division, then the set mapping, then a read and
// compare for each set scanned in turn through the single read port of the
// tag memory (up to set_count), then on a miss a read of the home set and,
// when the set was filled before, a division for the pointer update, then the
// write of the new tag, and then the result moves to the output register.
// A new item is taken only once the previous one sits in the output register,
// so the block does not take an item before it is through with the last.
// Reset clears all control state, the counters and the per-row valid flags of
// both memories at once; no clearing pass is needed.
// While the receiver stalls, the finished item holds in the output register
// and the next item is processed up to that point and then waits.
module set_assoc_cache_fifo_miss_classifier_top #(
    parameter int MAX_SETS = sacf_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS = sacf_pkg::DEF_MAX_WAYS,
    parameter int MEMORY_BLOCKS = sacf_pkg::DEF_MEMORY_BLOCKS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [sacf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sacf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [31:0]                         s_word_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_outcome,
    output logic [6:0]                          m_set_index,
    output logic [31:0]                         m_total_count,
    output logic [31:0]                         m_hit_count,
    output logic [31:0]                         m_miss_count,
    output logic [31:0]                         m_compulsory_count,
    output logic [31:0]                         m_capacity_count
);
    import sacf_pkg::*;

    localparam int TAGW = $clog2(MEMORY_BLOCKS);
    localparam int PTRW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SETW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int MAPROWS = (MEMORY_BLOCKS + 31) / 32;
    localparam int MAPAW = (MAPROWS > 1) ? $clog2(MAPROWS) : 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIV = 4'd1;
    localparam logic [3:0] ST_MOD = 4'd2;
    localparam logic [3:0] ST_SCAN_RD = 4'd3;
    localparam logic [3:0] ST_SCAN_CMP = 4'd4;
    localparam logic [3:0] ST_MISS_RD = 4'd5;
    localparam logic [3:0] ST_MISS_CHK = 4'd6;
    localparam logic [3:0] ST_PTR_DIV = 4'd7;
    localparam logic [3:0] ST_MISS_WR = 4'd8;
    localparam logic [3:0] ST_FIN = 4'd9;

    typedef struct packed {
        logic                           started;
        logic [PTRW-1:0]                ptr;
        logic [MAX_WAYS-1:0]            valid;
        logic [MAX_WAYS-1:0][TAGW-1:0]  tags;
    } row_t;

    logic [12:0] bw_reg;
    logic [7:0]  sets_reg;
    logic [3:0]  ways_reg;
    logic [12:0] bw_eff;
    logic [7:0]  sets_eff, ways_eff;

    logic [3:0]      state_reg, state_next;
    logic [TAGW-1:0] blk_reg, blk_next;
    logic [SETW-1:0] home_reg, home_next;
    logic [SETW-1:0] scan_reg, scan_next;
    logic [1:0]      res_out_reg, res_out_next;
    logic [SETW-1:0] res_set_reg, res_set_next;
    row_t            row_reg, row_next;
    logic [31:0]     map_row_reg, map_row_next;
    logic [PTRW-1:0] ptr_new_reg, ptr_new_next;

    logic [31:0] cnt_total_reg, cnt_hit_reg, cnt_miss_reg, cnt_comp_reg, cnt_cap_reg;
    logic        m_valid_reg;
    logic [1:0]  m_outcome_reg;
    logic [6:0]  m_set_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    row_t                     tag_mem [MAX_SETS];
    row_t                     tag_rd_reg;
    logic                     tag_rdv_reg;
    logic [MAX_SETS-1:0]      rowv_reg;
    logic                     tag_re, tag_we;
    logic [SETW-1:0]          tag_raddr;
    row_t                     tag_wdata;
    row_t                     row_eff;

    logic [31:0]              map_mem [MAPROWS];
    logic [31:0]              map_rd_reg;
    logic                     map_rdv_reg;
    logic [MAPROWS-1:0]       mapv_reg;
    logic                     map_re, map_we;
    logic [MAPAW-1:0]         map_addr;
    logic [31:0]              map_eff;
    logic [4:0]               map_bit;

    logic                     hit;
    logic                     out_free;
    logic [PTRW:0]            ptr_inc;

    sacf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        bw_eff = bw_reg;
        if (bw_reg == 13'd0) begin
            bw_eff = 13'd1;
        end else if (bw_reg > BLOCK_WORDS_LIMIT) begin
            bw_eff = BLOCK_WORDS_LIMIT;
        end
        sets_eff = sets_reg;
        if (sets_reg == 8'd0) begin
            sets_eff = 8'd1;
        end else if (sets_reg > 8'(MAX_SETS)) begin
            sets_eff = 8'(MAX_SETS);
        end
        ways_eff = {4'd0, ways_reg};
        if (ways_reg == 4'd0) begin
            ways_eff = 8'd1;
        end else if ({4'd0, ways_reg} > 8'(MAX_WAYS)) begin
            ways_eff = 8'(MAX_WAYS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bw_reg <= BLOCK_WORDS_RST;
            sets_reg <= SET_COUNT_RST;
            ways_reg <= WAY_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BLOCK_WORDS: bw_reg <= cfg_data;
                REG_SET_COUNT:   sets_reg <= cfg_data[7:0];
                REG_WAY_COUNT:   ways_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // A row that was never written reads as all ways invalid and a fresh pointer.
    assign row_eff = tag_rdv_reg ? tag_rd_reg : '0;
    assign map_eff = map_rdv_reg ? map_rd_reg : '0;
    assign map_bit = 5'(blk_reg);
    assign map_addr = MAPAW'(blk_reg >> 5);
    assign out_free = !m_valid_reg || m_ready;
    assign ptr_inc = {1'b0, row_eff.ptr} + 1'b1;

    always_comb begin
        hit = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (w < int'(ways_eff) && row_eff.valid[w] && row_eff.tags[w] == blk_reg) begin
                hit = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        blk_next = blk_reg;
        home_next = home_reg;
        scan_next = scan_reg;
        res_out_next = res_out_reg;
        res_set_next = res_set_reg;
        row_next = row_reg;
        map_row_next = map_row_reg;
        ptr_new_next = ptr_new_reg;
        div_req = '0;
        tag_re = 1'b0;
        tag_we = 1'b0;
        tag_raddr = scan_reg;
        tag_wdata = row_reg;
        map_re = 1'b0;
        map_we = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    div_req.start = 1'b1;
                    div_req.dividend = s_word_index;
                    div_req.divisor = bw_eff;
                    div_req.steps = STEP_W'(DVD_W);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient >= 32'(MEMORY_BLOCKS)) begin
                        res_out_next = OUT_RANGE;
                        res_set_next = '0;
                        state_next = ST_FIN;
                    end else begin
                        blk_next = TAGW'(div_rsp.quotient);
                        div_req.start = 1'b1;
                        div_req.dividend = div_rsp.quotient << (DVD_W - TAGW);
                        div_req.divisor = 13'(sets_eff);
                        div_req.steps = STEP_W'(TAGW);
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (div_rsp.done) begin
                    home_next = SETW'(div_rsp.remainder);
                    scan_next = '0;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                tag_re = 1'b1;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (hit) begin
                    res_out_next = OUT_HIT;
                    res_set_next = scan_reg;
                    state_next = ST_FIN;
                end else if (scan_reg == SETW'(sets_eff - 8'd1)) begin
                    state_next = ST_MISS_RD;
                end else begin
                    scan_next = scan_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MISS_RD: begin
                tag_re = 1'b1;
                tag_raddr = home_reg;
                map_re = 1'b1;
                state_next = ST_MISS_CHK;
            end
            ST_MISS_CHK: begin
                row_next = row_eff;
                map_row_next = map_eff;
                if (row_eff.started) begin
                    div_req.start = 1'b1;
                    div_req.dividend = 32'(ptr_inc) << (DVD_W - PTRW - 1);
                    div_req.divisor = 13'(ways_eff);
                    div_req.steps = STEP_W'(PTRW + 1);
                    state_next = ST_PTR_DIV;
                end else begin
                    ptr_new_next = '0;
                    state_next = ST_MISS_WR;
                end
            end
            ST_PTR_DIV: begin
                if (div_rsp.done) begin
                    ptr_new_next = PTRW'(div_rsp.remainder);
                    state_next = ST_MISS_WR;
                end
            end
            ST_MISS_WR: begin
                tag_we = 1'b1;
                tag_wdata.started = 1'b1;
                tag_wdata.ptr = ptr_new_reg;
                tag_wdata.valid[ptr_new_reg] = 1'b1;
                tag_wdata.tags[ptr_new_reg] = blk_reg;
                map_we = 1'b1;
                res_out_next = map_row_reg[map_bit] ? OUT_CAPACITY : OUT_COMPULSORY;
                res_set_next = home_reg;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[home_reg] <= tag_wdata;
        end
        if (tag_re) begin
            tag_rd_reg <= tag_mem[tag_raddr];
            tag_rdv_reg <= rowv_reg[tag_raddr];
        end
        if (map_we) begin
            map_mem[map_addr] <= map_row_reg | (32'd1 << map_bit);
        end
        if (map_re) begin
            map_rd_reg <= map_mem[map_addr];
            map_rdv_reg <= mapv_reg[map_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rowv_reg <= '0;
            mapv_reg <= '0;
            m_valid_reg <= 1'b0;
            cnt_total_reg <= '0;
            cnt_hit_reg <= '0;
            cnt_miss_reg <= '0;
            cnt_comp_reg <= '0;
            cnt_cap_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (tag_we) begin
                rowv_reg[home_reg] <= 1'b1;
            end
            if (map_we) begin
                mapv_reg[map_addr] <= 1'b1;
            end
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
                if (res_out_reg != OUT_RANGE) begin
                    cnt_total_reg <= cnt_total_reg + 1'b1;
                end
                if (res_out_reg == OUT_HIT) begin
                    cnt_hit_reg <= cnt_hit_reg + 1'b1;
                end
                if (res_out_reg == OUT_COMPULSORY || res_out_reg == OUT_CAPACITY) begin
                    cnt_miss_reg <= cnt_miss_reg + 1'b1;
                end
                if (res_out_reg == OUT_COMPULSORY) begin
                    cnt_comp_reg <= cnt_comp_reg + 1'b1;
                end
                if (res_out_reg == OUT_CAPACITY) begin
                    cnt_cap_reg <= cnt_cap_reg + 1'b1;
                end
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        blk_reg <= blk_next;
        home_reg <= home_next;
        scan_reg <= scan_next;
        res_out_reg <= res_out_next;
        res_set_reg <= res_set_next;
        row_reg <= row_next;
        map_row_reg <= map_row_next;
        ptr_new_reg <= ptr_new_next;
        if (state_reg == ST_FIN && out_free) begin
            m_outcome_reg <= res_out_reg;
            m_set_reg <= 7'(res_set_reg);
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_outcome = m_outcome_reg;
    assign m_set_index = m_set_reg;
    assign m_total_count = cnt_total_reg;
    assign m_hit_count = cnt_hit_reg;
    assign m_miss_count = cnt_miss_reg;
    assign m_compulsory_count = cnt_comp_reg;
    assign m_capacity_count = cnt_cap_reg;

endmodule

// ===== rtl/core/sacf_div.sv =====
module sacf_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  sacf_pkg::div_req_t req,
    output sacf_pkg::div_rsp_t rsp
);
    import sacf_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;
    logic [REM_W-1:0]   trial;
    logic               fits;

    // One quotient bit per cycle, restoring form; the dividend is left aligned.
    assign trial = {rem_reg[REM_W-2:0], dvd_reg[DVD_W-1]};
    assign fits = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next = req.steps;
            dvd_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? trial - {1'b0, dvs_reg} : trial;
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== rtl/core/sacf_chk.sv =====
module sacf_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_outcome,
    input logic [6:0]  m_set_index,
    input logic [31:0] m_total_count
);
    import sacf_pkg::*;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item taken while another is in work");

    a_range_set_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_outcome == OUT_RANGE |-> m_set_index == 7'd0)
        else $error("out-of-range item reports a set");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_count))
        else $error("stalled item changed");

endmodule

bind set_assoc_cache_fifo_miss_classifier_top sacf_chk u_sacf_chk (.*);

// ===== test/testbench.sv =====
module testbench;
    import sacf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct {
        logic [1:0]  outcome;
        logic [6:0]  set_index;
        logic [31:0] total;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] compulsory;
        logic [31:0] capacity;
    } access_result_t;

    typedef struct {
        logic [31:0] word;
        bit          known;
        logic [1:0]  outcome;
        logic [6:0]  set_index;
    } access_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_BLOCK_WORDS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [31:0] s_word_index = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_outcome;
    logic [6:0] m_set_index;
    logic [31:0] m_total_count, m_hit_count, m_miss_count;
    logic [31:0] m_compulsory_count, m_capacity_count;

    set_assoc_cache_fifo_miss_classifier_top DUT (.*);

    always #2 aclk = ~aclk;

    // Shadow copy of the tag store and its geometry.
    logic [12:0] geo_block_words;
    logic [7:0]  geo_sets;
    logic [3:0]  geo_ways;
    logic [9:0]  shadow_tag [DEF_MAX_SETS*DEF_MAX_WAYS];
    bit          shadow_valid [DEF_MAX_SETS*DEF_MAX_WAYS];
    logic [2:0]  shadow_ptr [DEF_MAX_SETS];
    bit          shadow_started [DEF_MAX_SETS];
    bit          touched [DEF_MEMORY_BLOCKS];
    logic [31:0] tally [5];

    access_result_t expected_results[$];
    int errors = 0;
    int accepted = 0;
    int checked = 0;
    bit calm = 1'b0;
    bit hold_off = 1'b0;
    bit send_done = 1'b0;

    task automatic clear_shadow();
        geo_block_words = BLOCK_WORDS_RST;
        geo_sets = SET_COUNT_RST;
        geo_ways = WAY_COUNT_RST;
        foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
        foreach (shadow_tag[i]) shadow_tag[i] = '0;
        foreach (shadow_ptr[i]) begin
            shadow_ptr[i] = '0;
            shadow_started[i] = 1'b0;
        end
        foreach (touched[i]) touched[i] = 1'b0;
        foreach (tally[i]) tally[i] = '0;
    endtask

    function automatic access_result_t classify_access(logic [31:0] word);
        access_result_t r;
        int bw, ns, nw, blk, home, slot;
        bw = (geo_block_words == 0) ? 1 : (geo_block_words > 4096 ? 4096 : geo_block_words);
        ns = (geo_sets == 0) ? 1 : (geo_sets > DEF_MAX_SETS ? DEF_MAX_SETS : geo_sets);
        nw = (geo_ways == 0) ? 1 : (geo_ways > DEF_MAX_WAYS ? DEF_MAX_WAYS : geo_ways);
        blk = int'(word / 32'(bw));
        r.outcome = OUT_RANGE;
        r.set_index = '0;
        if (word / 32'(bw) < DEF_MEMORY_BLOCKS) begin
            tally[0]++;
            home = -1;
            for (int s = 0; s < ns && home < 0; s++)
                for (int w = 0; w < nw && home < 0; w++) begin
                    slot = s*DEF_MAX_WAYS + w;
                    if (shadow_valid[slot] && shadow_tag[slot] == blk) home = s;
                end
            if (home >= 0) begin
                tally[1]++;
                r.outcome = OUT_HIT;
                r.set_index = 7'(home);
            end else begin
                home = blk % ns;
                if (!shadow_started[home]) begin
                    shadow_started[home] = 1'b1;
                    shadow_ptr[home] = '0;
                end else begin
                    shadow_ptr[home] = 3'((shadow_ptr[home] + 1) % nw);
                end
                slot = home*DEF_MAX_WAYS + shadow_ptr[home];
                shadow_tag[slot] = 10'(blk);
                shadow_valid[slot] = 1'b1;
                tally[2]++;
                r.set_index = 7'(home);
                if (!touched[blk]) begin
                    touched[blk] = 1'b1;
                    tally[3]++;
                    r.outcome = OUT_COMPULSORY;
                end else begin
                    tally[4]++;
                    r.outcome = OUT_CAPACITY;
                end
            end
        end
        r.total = tally[0];
        r.hits = tally[1];
        r.misses = tally[2];
        r.compulsory = tally[3];
        r.capacity = tally[4];
        return r;
    endfunction

    task automatic send_access(logic [31:0] word, bit known = 1'b0, logic [1:0] oc = '0,
                               logic [6:0] si = '0);
        access_result_t r;
        while (!calm && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        r = classify_access(word);
        if (known && r.outcome !== oc) begin
            $error("table outcome exp %0d got %0d", oc, r.outcome);
            errors++;
        end
        if (known && r.set_index !== si) begin
            $error("table set_index exp %0d got %0d", si, r.set_index);
            errors++;
        end
        expected_results.push_back(r);
        s_valid <= 1'b1;
        s_word_index <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        accepted++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [12:0] val);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_BLOCK_WORDS) geo_block_words = val;
        else if (idx == REG_SET_COUNT) geo_sets = val[7:0];
        else if (idx == REG_WAY_COUNT) geo_ways = val[3:0];
    endtask

    // Receiver side.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                access_result_t e;
                e = expected_results.pop_front();
                checked++;
                if (m_outcome !== e.outcome) begin
                    $error("outcome exp %0d got %0d", e.outcome, m_outcome); errors++;
                end
                if (m_set_index !== e.set_index) begin
                    $error("set_index exp %0d got %0d", e.set_index, m_set_index); errors++;
                end
                if (m_total_count !== e.total) begin
                    $error("total_count exp %0d got %0d", e.total, m_total_count); errors++;
                end
                if (m_hit_count !== e.hits) begin
                    $error("hit_count exp %0d got %0d", e.hits, m_hit_count); errors++;
                end
                if (m_miss_count !== e.misses) begin
                    $error("miss_count exp %0d got %0d", e.misses, m_miss_count); errors++;
                end
                if (m_compulsory_count !== e.compulsory) begin
                    $error("compulsory_count exp %0d got %0d", e.compulsory,
                           m_compulsory_count);
                    errors++;
                end
                if (m_capacity_count !== e.capacity) begin
                    $error("capacity_count exp %0d got %0d", e.capacity, m_capacity_count);
                    errors++;
                end
            end
        end
        m_ready <= aresetn && !hold_off && (calm || $urandom_range(99) >= 15);
    end

    initial begin
        #40000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        access_row_t rows[$];
        int n;
        logic [31:0] w;
        clear_shadow();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset geometry: 4 words per block, 8 sets, one way.
        rows.push_back('{32'd0, 1, OUT_COMPULSORY, 7'd0});
        rows.push_back('{32'd3, 1, OUT_HIT, 7'd0});
        rows.push_back('{32'd4, 1, OUT_COMPULSORY, 7'd1});
        rows.push_back('{32'd32, 1, OUT_COMPULSORY, 7'd0});
        rows.push_back('{32'd0, 1, OUT_CAPACITY, 7'd0});
        rows.push_back('{32'd4095, 1, OUT_COMPULSORY, 7'd7});
        rows.push_back('{32'd4096, 1, OUT_RANGE, 7'd0});
        rows.push_back('{32'hFFFFFFFF, 1, OUT_RANGE, 7'd0});
        rows.push_back('{32'h55555555, 1, OUT_RANGE, 7'd0});
        rows.push_back('{32'd36, 0, OUT_HIT, 7'd0});
        rows.push_back('{32'd68, 0, OUT_HIT, 7'd0});
        foreach (rows[i]) send_access(rows[i].word, rows[i].known, rows[i].outcome,
                                      rows[i].set_index);

        // Largest geometry, then out-of-range register values.
        write_reg(REG_BLOCK_WORDS, 13'd4096);
        write_reg(REG_SET_COUNT, 13'd128);
        write_reg(REG_WAY_COUNT, 13'd8);
        send_access(32'hFFFFFFFF);
        send_access(32'h003FFFFF);
        send_access(32'h00400000);
        send_access(32'hAAAAAAAA);
        write_reg(REG_BLOCK_WORDS, 13'h1FFF);
        write_reg(REG_SET_COUNT, 13'hFF);
        write_reg(REG_WAY_COUNT, 13'hF);
        send_access(32'h003FF000);
        send_access(32'h00001000);
        write_reg(REG_BLOCK_WORDS, 13'd0);
        write_reg(REG_SET_COUNT, 13'd0);
        write_reg(REG_WAY_COUNT, 13'd0);
        send_access(32'd1023);
        send_access(32'd1024);
        send_access(32'd5);
        send_access(32'd5);
        write_reg(REG_NONE, 13'd7);
        send_access(32'd9);

        // Random phases over several geometries; small sets keep scans short.
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(REG_BLOCK_WORDS, phase == 3 ? 13'h1FFF : 13'($urandom_range(1, 16)));
            write_reg(REG_SET_COUNT, phase == 5 ? 13'd128 : 13'($urandom_range(0, 12)));
            write_reg(REG_WAY_COUNT, 13'($urandom_range(0, 15)));
            calm = (phase == 2);
            if (phase == 4) fork
                begin
                    hold_off = 1'b1;
                    repeat (600) @(posedge aclk);
                    hold_off = 1'b0;
                end
            join_none
            for (int k = 0; k < 200; k++) begin
                n = $urandom_range(99);
                if (n < 8) w = $urandom;
                else if (n < 12) w = ~32'($urandom_range(0, 255));
                else w = $urandom_range(0, 48 * ((geo_block_words == 0) ? 1 : geo_block_words));
                send_access(w);
            end
            calm = 1'b0;
        end
        s_valid <= 1'b0;
        send_done = 1'b1;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("tb: %0d accesses sent, %0d results checked over 12 geometries",
                 accepted, checked);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
